>>> src/fatx_cluster_chain_lookup_core_macros.svh
// Assertion helpers for the cluster chain lookup core.
// Each helper checks on the rising edge of clk and is off while arst_n is low.
`ifndef FATX_CLUSTER_CHAIN_LOOKUP_CORE_MACROS_SVH
`define FATX_CLUSTER_CHAIN_LOOKUP_CORE_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define FCL_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cluster chain lookup check failed");

// The expression must never be true at a clock edge outside reset.
`define FCL_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("cluster chain lookup forbidden condition");

`else

`define FCL_ASSERT(label, prop)
`define FCL_ASSERT_NEVER(label, expr)

`endif

`endif

>>> src/fcl_pkg.sv
package fcl_pkg;

	// Chain table geometry.
	localparam int TABLE_ENTRIES = 65536;
	localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Chain entry markers for narrow and wide entries.
	localparam logic [31:0] NARROW_FIRST_MARK = 32'h0000_fff8;
	localparam logic [31:0] NARROW_MAX_OK     = 32'h0000_fff4;
	localparam logic [31:0] WIDE_FIRST_MARK   = 32'hffff_fff8;
	localparam logic [31:0] WIDE_MAX_OK       = 32'hffff_fff4;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_PART_START  = 3'd0;
	localparam logic [2:0] REG_DATA_START  = 3'd1;
	localparam logic [2:0] REG_SHIFT       = 3'd2;
	localparam logic [2:0] REG_COUNT       = 3'd3;
	localparam logic [2:0] REG_WIDE        = 3'd4;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_NEXT    = 3'd0,
		ST_EOC     = 3'd1,
		ST_RANGE   = 3'd2,
		ST_FREE    = 3'd3,
		ST_BAD     = 3'd4,
		ST_OUTSIDE = 3'd5,
		ST_WRITE   = 3'd6
	} status_t;

	// Configuration register set.
	typedef struct packed {
		logic [31:0] part_start;
		logic [31:0] data_start;
		logic [2:0]  shift;
		logic [31:0] count;
		logic        wide;
	} cfg_t;

	// One queued item on its way to classification.
	typedef struct packed {
		logic        is_write;
		logic        range_ok;
		logic [31:0] entry;
		logic [31:0] sector;
	} qent_t;

	// Push side of the queue.
	typedef struct packed {
		logic  valid;
		qent_t data;
	} push_t;

endpackage

>>> src/fatx_cluster_chain_lookup_core.sv
// Cluster chain lookup core. Write items load the 65536-entry chain table one
// entry at a time; lookup items check the cluster against the partition and
// the table, read its entry in 16-bit or 32-bit mode, classify it and give the
// absolute first sector of the cluster. The block sustains one item per clock
// cycle while in_stall and out_stall stay low, set by the single port of the
// chain table memory, which serves one read or one write each cycle. A result
// passes the stage one register with the table read, then the queue, then the
// output register. Table entries are undefined until written and are not
// cleared after reset; a lookup of an entry that was never written returns
// whatever the memory holds. The user must write the configuration registers
// only while the block holds no item; the block itself does not enforce this.
`include "fatx_cluster_chain_lookup_core_macros.svh"

module fatx_cluster_chain_lookup_core
	import fcl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] cluster,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_cluster,
	output logic [2:0]  status,
	output logic [31:0] cluster_sector
);

	cfg_t                cfg_q;
	logic                cfg_wr;
	logic                ram_we;
	logic                ram_re;
	logic [TABLE_AW-1:0] ram_addr;
	logic [31:0]         ram_wdata;
	logic [31:0]         ram_rdata;
	push_t               push;
	logic                pop;
	logic                q_empty;
	qent_t               q_head;
	logic [QCW-1:0]      q_level;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_PART_START: cfg_q.part_start <= pwdata;
				REG_DATA_START: cfg_q.data_start <= pwdata;
				REG_SHIFT:      cfg_q.shift      <= pwdata[2:0];
				REG_COUNT:      cfg_q.count      <= pwdata;
				REG_WIDE:       cfg_q.wide       <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[4:2])
			REG_PART_START: prdata = cfg_q.part_start;
			REG_DATA_START: prdata = cfg_q.data_start;
			REG_SHIFT:      prdata = {29'd0, cfg_q.shift};
			REG_COUNT:      prdata = cfg_q.count;
			REG_WIDE:       prdata = {31'd0, cfg_q.wide};
			default:        prdata = 32'd0;
		endcase
	end

	// Chain table memory.
	fcl_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Front: accepts items, checks ranges and drives the table.
	fcl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.operation   (operation),
		.cluster     (cluster),
		.entry_value (entry_value),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.q_level     (q_level),
		.ram_we      (ram_we),
		.ram_re      (ram_re),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata),
		.push        (push)
	);

	// Queue between front and back.
	fcl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.empty  (q_empty),
		.head   (q_head),
		.level  (q_level)
	);

	// Back: classifies entries and holds the result.
	fcl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.empty          (q_empty),
		.head           (q_head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_cluster   (next_cluster),
		.status         (status),
		.cluster_sector (cluster_sector)
	);

	// The queue never has to take more items than it holds.
	`FCL_ASSERT_NEVER(a_queue_overflow, push.valid && (q_level == QCW'(QDEPTH)) && !pop)

	// A write result carries no cluster and no sector.
	`FCL_ASSERT(a_write_zero, (out_valid && (status == ST_WRITE)) |-> ((next_cluster == 32'd0) && (cluster_sector == 32'd0)))

	// Only a valid next cluster result carries a cluster number.
	`FCL_ASSERT(a_next_zero, (out_valid && (status != ST_NEXT)) |-> (next_cluster == 32'd0))

	// A lookup that misses the range carries no sector.
	`FCL_ASSERT(a_range_zero, (out_valid && (status == ST_RANGE)) |-> (cluster_sector == 32'd0))

endmodule

>>> src/fcl_ram.sv
module fcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> src/fcl_front.sv
module fcl_front
	import fcl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                operation,
	input  logic [31:0]         cluster,
	input  logic [31:0]         entry_value,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [QCW-1:0]      q_level,
	output logic                ram_we,
	output logic                ram_re,
	output logic [TABLE_AW-1:0] ram_addr,
	output logic [31:0]         ram_wdata,
	input  logic [31:0]         ram_rdata,
	output push_t               push
);

	logic        accept;
	logic        in_table;
	logic        range_ok;
	logic [QCW:0] occupancy;
	logic        valid_s1;
	logic        is_write_s1;
	logic        range_ok_s1;
	logic [31:0] offset_s1;

	// Hold off new items when the queue cannot take the one in flight plus another.
	assign occupancy = {1'b0, q_level} + {{QCW{1'b0}}, valid_s1};
	assign in_stall  = (occupancy >= (QCW + 1)'(QDEPTH));
	assign accept    = in_valid && !in_stall;

	// Range checks on the incoming cluster number.
	assign in_table = (cluster[31:TABLE_AW] == '0);
	assign range_ok = (cluster != 32'd0) && (cluster < cfg.count) && in_table;

	// Table access: writes outside the table are dropped, lookups always read.
	assign ram_we    = accept && operation && in_table;
	assign ram_re    = accept && !operation;
	assign ram_addr  = cluster[TABLE_AW-1:0];
	assign ram_wdata = cfg.wide ? entry_value : {16'h0000, entry_value[15:0]};

	// Stage one waits for the table read and carries the cluster offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_write_s1 <= operation;
			range_ok_s1 <= range_ok;
			offset_s1   <= (cluster - 32'd1) << cfg.shift;
		end
	end

	// Combine read data and the sector address into a queue entry.
	always_comb begin
		push.valid         = valid_s1;
		push.data.is_write = is_write_s1;
		push.data.range_ok = range_ok_s1;
		push.data.entry    = cfg.wide ? ram_rdata : {16'h0000, ram_rdata[15:0]};
		if (range_ok_s1 && !is_write_s1) begin
			push.data.sector = cfg.part_start + cfg.data_start + offset_s1;
		end else begin
			push.data.sector = 32'd0;
		end
	end

endmodule

>>> src/fcl_queue.sv
module fcl_queue
	import fcl_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  push_t          push,
	input  logic           pop,
	output logic           empty,
	output qent_t          head,
	output logic [QCW-1:0] level
);

	qent_t          slots [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] level_q;
	logic           do_pop;

	assign empty  = (level_q == '0);
	assign head   = slots[rd_ptr_q];
	assign level  = level_q;
	assign do_pop = pop && !empty;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots[wr_ptr_q] <= push.data;
		end
	end

endmodule

>>> src/fcl_back.sv
module fcl_back
	import fcl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        empty,
	input  qent_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_cluster,
	output logic [2:0]  status,
	output logic [31:0] cluster_sector
);

	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] next_q;
	logic [31:0] sector_q;
	status_t     status_d;
	logic [31:0] next_d;
	logic [31:0] first_mark;
	logic [31:0] max_ok;

	// Take the next item when the output register is free or being emptied.
	assign pop = !empty && (!out_valid_q || !out_stall);

	assign first_mark = cfg.wide ? WIDE_FIRST_MARK : NARROW_FIRST_MARK;
	assign max_ok     = cfg.wide ? WIDE_MAX_OK : NARROW_MAX_OK;

	// Classify the chain entry of a lookup; writes and range misses get their own status.
	always_comb begin
		next_d = 32'd0;
		if (head.is_write) begin
			status_d = ST_WRITE;
		end else if (!head.range_ok) begin
			status_d = ST_RANGE;
		end else if (head.entry >= first_mark) begin
			status_d = ST_EOC;
		end else if (head.entry == 32'd0) begin
			status_d = ST_FREE;
		end else if (head.entry > max_ok) begin
			status_d = ST_BAD;
		end else if (head.entry >= cfg.count) begin
			status_d = ST_OUTSIDE;
		end else begin
			status_d = ST_NEXT;
			next_d   = head.entry;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_d;
			next_q   <= next_d;
			sector_q <= head.sector;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign next_cluster   = next_q;
	assign cluster_sector = sector_q;

endmodule
